// File: rtl/bps_pkg.sv
// Shared types, constants and the tone pattern table for the buzzer
// pattern sequencer. No dependencies.
package bps_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEEP_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYSTEM_READY = 2'd1;

   // opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BEEP = 1'b1;

   // request / pattern codes
   localparam logic [3:0] CODE_FORCE    = 4'd0;
   localparam logic [3:0] PAT_MELODY    = 4'd6;
   localparam logic [3:0] PAT_SIXTY     = 4'd8;
   localparam logic [3:0] PAT_NINETY    = 4'd9;
   localparam logic [3:0] PAT_LAST      = 4'd9;
   localparam logic [3:0] PAT_IDLE      = 4'd15;

   localparam logic [9:0] HZ_BEEP   = 10'd833;
   localparam logic [9:0] HZ_NOTE_C = 10'd523;
   localparam logic [9:0] HZ_NOTE_E = 10'd659;
   localparam logic [9:0] HZ_NOTE_G = 10'd784;
   localparam logic [6:0] DUTY_HALF = 7'd50;
   localparam logic [7:0] TICKS_BEEP  = 8'd5;
   localparam logic [7:0] TICKS_GAP   = 8'd4;
   localparam logic [7:0] TICKS_SHORT = 8'd20;
   localparam logic [7:0] TICKS_LONG  = 8'd30;

   typedef struct packed {
      logic       opcode;
      logic [3:0] request_code;
   } req_type;

   typedef struct packed {
      logic [9:0] tone_hz;
      logic [6:0] duty_pct;
      logic       tone_active;
      logic       busy_res;
      logic [3:0] queue_level;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       is_beep;
      logic       allowed;
      logic [3:0] code;
   } cmd_type;

   typedef struct packed {
      logic       valid;   // step lies inside the pattern
      logic [9:0] hz;
      logic [6:0] duty;
      logic [7:0] ticks;
   } note_type;

   function automatic note_type beep_note(input logic valid);
      note_type n;
      n.valid = valid;
      n.hz    = HZ_BEEP;
      n.duty  = DUTY_HALF;
      n.ticks = TICKS_BEEP;
      return n;
   endfunction

   function automatic note_type gap_note(input logic valid);
      note_type n;
      n.valid = valid;
      n.hz    = '0;
      n.duty  = '0;
      n.ticks = TICKS_GAP;
      return n;
   endfunction

   // note of pattern pat at step idx; pat must be a playable code
   function automatic note_type pattern_note(input logic [3:0] pat, input logic [2:0] idx);
      note_type n;
      n = beep_note(idx == 3'd0);
      case (pat)
         PAT_MELODY: begin
            n.valid = (idx < 3'd3);
            n.duty  = DUTY_HALF;
            case (idx)
               3'd0:    begin n.hz = HZ_NOTE_C; n.ticks = TICKS_SHORT; end
               3'd1:    begin n.hz = HZ_NOTE_E; n.ticks = TICKS_SHORT; end
               default: begin n.hz = HZ_NOTE_G; n.ticks = TICKS_LONG;  end
            endcase
         end
         PAT_SIXTY: begin
            if (idx == 3'd1) n = gap_note(1'b1);
            else             n = beep_note(idx < 3'd3);
         end
         PAT_NINETY: begin
            if (idx[0]) n = gap_note(idx < 3'd5);
            else        n = beep_note(idx < 3'd5);
         end
         default: n = beep_note(idx == 3'd0);
      endcase
      return n;
   endfunction

endpackage

// File: rtl/buzzer_pattern_sequencer_unit.sv
// Buzzer pattern sequencer: every request (a timer tick or a beep request)
// returns exactly one status response, in order. One request is taken per
// clock while the queues have room. A response passes through the front
// command queue, from which the sequencer takes the command and updates all
// state in a single step, and then the response queue before it can be
// popped. Two-entry queues on each side let pushes continue while up to two
// responses wait to be popped.
// Configuration writes are always ready and belong in idle periods.
// Top level; instantiates bps_front and bps_back, uses bps_pkg.
module buzzer_pattern_sequencer_unit
   import bps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_item,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_item;

   assign csr_ready = 1'b1;

   bps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_take  (cmd_take),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item)
   );

   bps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_take  (cmd_take),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/bps_front.sv
// Front end: holds the configuration bits, classifies incoming requests
// and keeps them in a two-entry command queue. Uses bps_pkg.
module bps_front
   import bps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_item,
   output logic                   req_full,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_data,
   input  logic                   cmd_take,
   output logic                   cmd_valid,
   output cmd_type                cmd_item
);

   logic       beep_enable_ff,  beep_enable_in;
   logic       system_ready_ff, system_ready_in;
   cmd_type    cmd_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push_ok;
   logic       pop_ok;
   cmd_type    classified;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_item  = cmd_mem_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      classified.is_beep = (req_item.opcode == OP_BEEP);
      classified.code    = req_item.request_code;
      classified.allowed = beep_enable_ff &&
                           (system_ready_ff || req_item.request_code == CODE_FORCE);
   end

   always_comb begin
      beep_enable_in  = beep_enable_ff;
      system_ready_in = system_ready_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BEEP_ENABLE:  beep_enable_in  = csr_data;
            CSR_SYSTEM_READY: system_ready_in = csr_data;
            default: ;
         endcase
      end
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_enable_ff  <= 1'b0;
         system_ready_ff <= 1'b0;
         wr_ptr_ff       <= 1'b0;
         rd_ptr_ff       <= 1'b0;
         count_ff        <= 2'd0;
      end else begin
         beep_enable_ff  <= beep_enable_in;
         system_ready_ff <= system_ready_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) cmd_mem_ff[wr_ptr_ff] <= classified;
   end

endmodule

// File: rtl/bps_back.sv
// Back end: request queue, tone timer and pattern sequencer; one command
// per cycle while the output queue can take its result; results go into a two-entry output queue. Uses bps_pkg.
module bps_back
   import bps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_item,
   output logic    cmd_take,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_item
);

   logic [3:0]        store_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] ridx_ff, ridx_in;
   logic [QIDX_W-1:0] widx_ff, widx_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic [3:0]        pat_ff, pat_in;
   logic [2:0]        step_ff, step_in;
   logic [7:0]        timer_ff, timer_in;
   logic              holdoff_ff, holdoff_in;
   logic [9:0]        freq_ff, freq_in;
   logic [6:0]        duty_ff, duty_in;
   logic              sounding_ff, sounding_in;
   logic              store_wr;

   rsp_type    res_mem_ff [2];
   logic       res_wr_ff, res_rd_ff;
   logic [1:0] res_count_ff, res_count_in;
   logic       res_pop;
   rsp_type    result;
   note_type   note;

   assign rsp_empty = (res_count_ff == 2'd0);
   assign rsp_item  = res_mem_ff[res_rd_ff];
   assign res_pop   = rsp_pop && !rsp_empty;
   assign cmd_take  = cmd_valid && ((res_count_ff != 2'd2) || res_pop);
   assign note      = pattern_note(pat_ff, step_ff);

   always_comb begin
      ridx_in     = ridx_ff;
      widx_in     = widx_ff;
      fill_in     = fill_ff;
      pat_in      = pat_ff;
      step_in     = step_ff;
      timer_in    = timer_ff;
      holdoff_in  = holdoff_ff;
      freq_in     = freq_ff;
      duty_in     = duty_ff;
      sounding_in = sounding_ff;
      store_wr    = 1'b0;
      if (cmd_item.is_beep) begin
         if (cmd_item.allowed && !holdoff_ff && fill_ff != QCNT_W'(QUEUE_DEPTH)) begin
            store_wr   = 1'b1;
            widx_in    = (widx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
            fill_in    = fill_ff + 1'b1;
            holdoff_in = 1'b1;
         end
      end else begin
         holdoff_in = 1'b0;
         if (timer_ff != 8'd0) timer_in = timer_ff - 8'd1;
         if (timer_in == 8'd0) begin
            if (pat_ff <= PAT_LAST) begin
               if (note.valid) begin
                  freq_in     = note.hz;
                  duty_in     = note.duty;
                  timer_in    = note.ticks;
                  sounding_in = (note.hz != 10'd0);
                  step_in     = step_ff + 3'd1;
               end else begin
                  // off step closes the pattern
                  freq_in     = '0;
                  duty_in     = '0;
                  sounding_in = 1'b0;
                  step_in     = '0;
                  pat_in      = PAT_IDLE;
               end
            end else if (fill_ff != '0) begin
               pat_in  = store_ff[ridx_ff];
               ridx_in = (ridx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : ridx_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               step_in = '0;
            end
         end
      end
      result.tone_hz     = freq_in;
      result.duty_pct    = duty_in;
      result.tone_active = sounding_in;
      result.busy_res    = (pat_in <= PAT_LAST);
      result.queue_level = 4'(fill_in);
      res_count_in = res_count_ff + {1'b0, cmd_take} - {1'b0, res_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ridx_ff      <= '0;
         widx_ff      <= '0;
         fill_ff      <= '0;
         pat_ff       <= PAT_IDLE;
         step_ff      <= '0;
         timer_ff     <= '0;
         holdoff_ff   <= 1'b0;
         freq_ff      <= '0;
         duty_ff      <= '0;
         sounding_ff  <= 1'b0;
         res_wr_ff    <= 1'b0;
         res_rd_ff    <= 1'b0;
         res_count_ff <= 2'd0;
      end else begin
         if (cmd_take) begin
            ridx_ff     <= ridx_in;
            widx_ff     <= widx_in;
            fill_ff     <= fill_in;
            pat_ff      <= pat_in;
            step_ff     <= step_in;
            timer_ff    <= timer_in;
            holdoff_ff  <= holdoff_in;
            freq_ff     <= freq_in;
            duty_ff     <= duty_in;
            sounding_ff <= sounding_in;
            res_wr_ff   <= ~res_wr_ff;
         end
         if (res_pop) res_rd_ff <= ~res_rd_ff;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take && store_wr) store_ff[widx_ff] <= cmd_item.code;
      if (cmd_take) res_mem_ff[res_wr_ff] <= result;
   end

endmodule
